// ===== rtl/line_point_generator_macros.svh =====
// Assertion macros used by the line point generator checker
`ifndef LINE_POINT_GENERATOR_MACROS_SVH
`define LINE_POINT_GENERATOR_MACROS_SVH

// clocked check, off while reset is high
`define LPG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check, also live during reset
`define LPG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/lpg_pkg.sv =====
// Shared types and constants for the line point generator
package lpg_pkg;

   localparam int LPG_COORD_BITS = 10;
   localparam int LPG_COLOR_BITS = 16;

   typedef enum logic {
      ACT_START = 1'b0,
      ACT_NEXT  = 1'b1
   } lpg_action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } lpg_state_type;

endpackage

// ===== rtl/lpg_divider.sv =====
// Iterative radix-2 restoring divider, one quotient bit per cycle
module lpg_divider #(
   parameter int DIVIDEND_BITS = 2 * lpg_pkg::LPG_COORD_BITS,
   parameter int DIVISOR_BITS  = lpg_pkg::LPG_COORD_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic [DIVIDEND_BITS-1:0] quotient,
   output logic                     done
);

   localparam int CountBits = $clog2(DIVIDEND_BITS + 1);

   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff;
   logic [CountBits-1:0]     count_ff;
   logic                     busy_ff;
   logic                     done_ff;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS+1:0]  diff;
   logic                     fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      fits    = ~diff[DIVISOR_BITS+1];
      rem_in  = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
      quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && (count_ff == CountBits'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CountBits'(DIVIDEND_BITS);
         end else if (busy_ff) begin
            count_ff <= count_ff - CountBits'(1);
            if (count_ff == CountBits'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// ===== rtl/line_point_generator.sv =====
// Flow: a start item is taken while idle and gives no result. A next item, while a line is
// pending, passes through ST_MULT, ST_DIV_START, ST_DIV_WAIT (bit-serial divider) and ST_EMIT
// into the output register; ST_MULT goes straight to ST_EMIT when both endpoints match.
// ST_EMIT holds while rsp_tready is low, and a new next item waits until the point is loaded;
// req_tready is low while a point is being worked out. Start items: one a cycle while idle.
// Reset: synchronous, clears the pending line and the output valid.
module line_point_generator #(
   parameter int  COORD_BITS = lpg_pkg::LPG_COORD_BITS,
   localparam int REQ_BITS   = ((4 * COORD_BITS + lpg_pkg::LPG_COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((2 * COORD_BITS + lpg_pkg::LPG_COLOR_BITS + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // x_start, y_start, x_end, y_end, pen_color
   input  logic [REQ_BITS-1:0] req_tdata,
   // action
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // point_x, point_y, pixel_colour
   output logic [RSP_BITS-1:0] rsp_tdata,
   output logic                rsp_tlast
);

   import lpg_pkg::*;

   localparam int ProdBits = 2 * COORD_BITS + 2;
   localparam int MagBits  = 2 * COORD_BITS;

   lpg_state_type state_ff, state_in;

   logic                         line_active_ff;
   logic                         y_major_ff;
   logic [COORD_BITS-1:0]        major_origin_ff;
   logic [COORD_BITS-1:0]        major_current_ff;
   logic [COORD_BITS-1:0]        major_span_ff;
   logic [COORD_BITS-1:0]        minor_origin_ff;
   logic signed [COORD_BITS:0]   minor_delta_ff;
   logic [LPG_COLOR_BITS-1:0]    line_color_ff;
   logic signed [ProdBits-1:0]   product_ff;
   logic                         rsp_valid_ff;
   logic [RSP_BITS-1:0]          rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff;

   logic [COORD_BITS-1:0]        x_start, y_start, x_end, y_end;
   logic [LPG_COLOR_BITS-1:0]    pen_color;
   logic signed [COORD_BITS:0]   dx, dy, delta_in;
   logic [COORD_BITS-1:0]        adx, ady;
   logic                         y_major_in;
   logic [COORD_BITS-1:0]        ma, mb, na, nb;
   logic [COORD_BITS-1:0]        near_major, far_major, near_minor, far_minor;

   logic                         start_accept;
   logic                         next_accept;
   logic                         div_start;
   logic                         emit_load;
   logic                         span_zero;
   logic [COORD_BITS-1:0]        offset;
   logic signed [ProdBits-1:0]   product_in;
   logic                         prod_neg;
   logic [ProdBits-1:0]          prod_abs;
   logic [MagBits-1:0]           quotient;
   logic                         div_done;
   logic [COORD_BITS-1:0]        q_lo, q_signed, minor_point;
   logic                         last_in;

   assign x_start   = req_tdata[COORD_BITS-1:0];
   assign y_start   = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign x_end     = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign y_end     = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
   assign pen_color = req_tdata[4*COORD_BITS+LPG_COLOR_BITS-1:4*COORD_BITS];

   // endpoint ordering on a start item
   always_comb begin
      dx         = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
      dy         = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
      adx        = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ady        = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      y_major_in = ady > adx;
      ma         = y_major_in ? y_start : x_start;
      mb         = y_major_in ? y_end   : x_end;
      na         = y_major_in ? x_start : y_start;
      nb         = y_major_in ? x_end   : y_end;
      if (ma > mb) begin
         near_major = mb;
         far_major  = ma;
         near_minor = nb;
         far_minor  = na;
      end else begin
         near_major = ma;
         far_major  = mb;
         near_minor = na;
         far_minor  = nb;
      end
      delta_in = $signed({1'b0, far_minor}) - $signed({1'b0, near_minor});
   end

   assign start_accept = req_tvalid && req_tready && (req_tuser == ACT_START);
   assign next_accept  = req_tvalid && req_tready && (req_tuser == ACT_NEXT);

   assign offset     = major_current_ff - major_origin_ff;
   assign span_zero  = (major_span_ff == '0);
   assign product_in = $signed({1'b0, offset}) * minor_delta_ff;
   assign prod_neg   = product_ff[ProdBits-1];
   assign prod_abs   = prod_neg ? ProdBits'(-product_ff) : ProdBits'(product_ff);

   lpg_divider #(
      .DIVIDEND_BITS(MagBits),
      .DIVISOR_BITS (COORD_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(prod_abs[MagBits-1:0]),
      .divisor (major_span_ff),
      .quotient(quotient),
      .done    (div_done)
   );

   always_comb begin
      q_lo        = span_zero ? '0 : quotient[COORD_BITS-1:0];
      q_signed    = prod_neg ? COORD_BITS'(-q_lo) : q_lo;
      minor_point = minor_origin_ff + q_signed;
      last_in     = offset >= major_span_ff;
      rsp_data_in = '0;
      if (y_major_ff) begin
         rsp_data_in[COORD_BITS-1:0]            = minor_point;
         rsp_data_in[2*COORD_BITS-1:COORD_BITS] = major_current_ff;
      end else begin
         rsp_data_in[COORD_BITS-1:0]            = major_current_ff;
         rsp_data_in[2*COORD_BITS-1:COORD_BITS] = minor_point;
      end
      rsp_data_in[2*COORD_BITS+LPG_COLOR_BITS-1:2*COORD_BITS] = line_color_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (next_accept && line_active_ff) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            state_in = span_zero ? ST_EMIT : ST_DIV_START;
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      emit_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_DIV_START: div_start  = 1'b1;
         ST_EMIT:      emit_load  = !rsp_valid_ff || rsp_tready;
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start_accept) begin
            line_active_ff <= 1'b1;
         end else if (emit_load && last_in) begin
            line_active_ff <= 1'b0;
         end
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_accept) begin
         y_major_ff       <= y_major_in;
         major_origin_ff  <= near_major;
         major_current_ff <= near_major;
         major_span_ff    <= far_major - near_major;
         minor_origin_ff  <= near_minor;
         minor_delta_ff   <= delta_in;
         line_color_ff    <= pen_color;
      end else if (emit_load && !last_in) begin
         major_current_ff <= major_current_ff + COORD_BITS'(1);
      end
      if (state_ff == ST_MULT) begin
         product_ff <= product_in;
      end
      if (emit_load) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/lpg_checker.sv =====
// Port-level checks for the line point generator, bound to the top level
`include "line_point_generator_macros.svh"

module lpg_checker #(
   parameter int  COORD_BITS = lpg_pkg::LPG_COORD_BITS,
   localparam int REQ_BITS   = ((4 * COORD_BITS + lpg_pkg::LPG_COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((2 * COORD_BITS + lpg_pkg::LPG_COLOR_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [REQ_BITS-1:0] req_tdata,
   input logic                req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   import lpg_pkg::*;

   `LPG_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "rsp valid after reset")

   `LPG_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp item changed while stalled")

   `LPG_ASSERT(a_start_keeps_ready, req_tvalid && req_tready && (req_tuser == ACT_START) |=> req_tready, "busy after a start item")

   `LPG_ASSERT(a_point_after_busy, $rose(rsp_tvalid) |-> !$past(req_tready), "point shown without work cycles")

   // request data only matters when valid
   `LPG_ASSERT(a_req_data_known, req_tvalid |-> !$isunknown(req_tdata), "req data unknown")

endmodule

bind line_point_generator lpg_checker #(.COORD_BITS(COORD_BITS)) u_lpg_checker (.*);

// ===== sim/line_point_generator_test.sv =====
// Testbench for the line point generator: queued line commands, predicted points, stream checks
`timescale 1ns / 100ps

module line_point_generator_test;
   import lpg_pkg::*;

   localparam int CB        = LPG_COORD_BITS;
   localparam int REQ_BITS  = ((4 * CB + LPG_COLOR_BITS + 7) / 8) * 8;
   localparam int RSP_BITS  = ((2 * CB + LPG_COLOR_BITS + 7) / 8) * 8;
   localparam int COORD_MAX = (1 << CB) - 1;
   localparam int ITEM_GOAL = 1450;
   localparam int RUN_LIMIT = 600000;
   localparam int DRAIN     = 3 * (2 * CB + 4);

   typedef logic [CB-1:0]             coord_type;
   typedef logic [LPG_COLOR_BITS-1:0] color_type;

   typedef struct {
      lpg_action_type action;
      coord_type      x0, y0, x1, y1;
      color_type      color;
      int             gap;
      bit             hold;
   } line_cmd_type;

   typedef struct {
      coord_type px, py;
      color_type color;
      logic      last;
   } pixel_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tlast;

   line_cmd_type cmds_due[$];
   pixel_type    pixels_due[$];
   line_cmd_type cur_cmd;
   bit        loaded = 1'b0;
   bit        shown = 1'b0;
   int        fail_count = 0;
   int        cycle_count = 0;
   int        send_calm = 0;
   int        recv_calm = 0;
   int        recv_stall = 0;
   int        counted = 0;

   // predictor state
   bit        line_on = 1'b0;
   bit        steep = 1'b0;
   coord_type maj_base = '0;
   coord_type maj_pos = '0;
   coord_type maj_len = '0;
   coord_type min_base = '0;
   int        min_diff = 0;
   color_type line_color = '0;

   line_point_generator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 30) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 14);
   endfunction

   task automatic track_item(input line_cmd_type c);
      int        dx, dy, ax, ay, q;
      coord_type ma, mb, na, nb, t, offs;
      pixel_type px;
      if (c.action == ACT_START) begin
         dx = int'(c.x1) - int'(c.x0);
         dy = int'(c.y1) - int'(c.y0);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         steep = ay > ax;
         if (steep) begin
            ma = c.y0; mb = c.y1; na = c.x0; nb = c.x1;
         end else begin
            ma = c.x0; mb = c.x1; na = c.y0; nb = c.y1;
         end
         if (ma > mb) begin
            t = ma; ma = mb; mb = t;
            t = na; na = nb; nb = t;
         end
         maj_base   = ma;
         maj_pos    = ma;
         maj_len    = mb - ma;
         min_base   = na;
         min_diff   = int'(nb) - int'(na);
         line_color = c.color;
         line_on    = 1'b1;
      end else if (line_on) begin
         offs = maj_pos - maj_base;
         q = 0;
         if (maj_len != 0) q = (int'(offs) * min_diff) / int'(maj_len);
         if (steep) begin
            px.px = coord_type'(int'(min_base) + q);
            px.py = maj_pos;
         end else begin
            px.px = maj_pos;
            px.py = coord_type'(int'(min_base) + q);
         end
         px.color = line_color;
         px.last  = offs >= maj_len;
         pixels_due.push_back(px);
         if (px.last) line_on = 1'b0;
         else maj_pos = maj_pos + 1'b1;
      end
   endtask

   task automatic add_cmd(input lpg_action_type act, input int x0, y0, x1, y1, color,
                          input bit hold = 1'b0);
      line_cmd_type c;
      c.action = act;
      c.x0     = coord_type'(x0);
      c.y0     = coord_type'(y0);
      c.x1     = coord_type'(x1);
      c.y1     = coord_type'(y1);
      c.color  = color_type'(color);
      c.gap    = draw_wait(send_calm);
      c.hold   = hold || ($urandom_range(0, 150) == 0);
      cmds_due.push_back(c);
   endtask

   task automatic add_next(input bit hold = 1'b0);
      add_cmd(ACT_NEXT, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
              $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
              $urandom_range(0, 16'hFFFF), hold);
   endtask

   function automatic int fit_end(input int a, input int d);
      if (a + d >= 0 && a + d <= COORD_MAX) return a + d;
      return a - d;
   endfunction

   task automatic add_random_line();
      int r, len, side, dmaj, dmin, dx, dy, x0, y0, x1, y1, span, n, ax, ay;
      r = $urandom_range(0, 99);
      x0 = $urandom_range(0, COORD_MAX);
      y0 = $urandom_range(0, COORD_MAX);
      if (r < 4) begin
         x1 = $urandom_range(0, COORD_MAX);
         y1 = $urandom_range(0, COORD_MAX);
      end else begin
         len  = (r < 70) ? $urandom_range(0, 12) : $urandom_range(13, 60);
         side = $urandom_range(0, len);
         dmaj = $urandom_range(0, 1) ? len : -len;
         dmin = $urandom_range(0, 1) ? side : -side;
         if ($urandom_range(0, 1)) begin
            dx = dmin; dy = dmaj;
         end else begin
            dx = dmaj; dy = dmin;
         end
         x1 = fit_end(x0, dx);
         y1 = fit_end(y0, dy);
      end
      ax = x1 > x0 ? x1 - x0 : x0 - x1;
      ay = y1 > y0 ? y1 - y0 : y0 - y1;
      span = ax > ay ? ax : ay;
      r = $urandom_range(0, 99);
      if (span > 60) n = $urandom_range(0, 30);
      else if (r < 12) n = $urandom_range(0, span);
      else if (r < 22) n = span + 1 + $urandom_range(1, 3);
      else n = span + 1;
      add_cmd(ACT_START, x0, y0, x1, y1, $urandom_range(0, 16'hFFFF));
      repeat (n) add_next();
      counted += 1 + n;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_item(cur_cmd);
            loaded = 1'b0;
            shown  = 1'b0;
         end
         if (!loaded && cmds_due.size() != 0) begin
            cur_cmd = cmds_due.pop_front();
            loaded  = 1'b1;
         end
         if (loaded && !shown) begin
            if (cur_cmd.gap != 0) cur_cmd.gap--;
            else if (!cur_cmd.hold || pixels_due.size() == 0) shown = 1'b1;
         end
         req_tvalid <= shown;
         if (loaded) begin
            req_tdata <= REQ_BITS'({cur_cmd.color, cur_cmd.y1, cur_cmd.x1,
                                    cur_cmd.y0, cur_cmd.x0});
            req_tuser <= cur_cmd.action;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pixels_due.size() == 0) begin
               $error("unexpected point item: x %0d y %0d", rsp_tdata[CB-1:0],
                      rsp_tdata[2*CB-1:CB]);
               fail_count++;
            end else begin
               want = pixels_due.pop_front();
               if (rsp_tdata[CB-1:0] !== want.px) begin
                  $error("point_x: expected %0d, actual %0d", want.px, rsp_tdata[CB-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[2*CB-1:CB] !== want.py) begin
                  $error("point_y: expected %0d, actual %0d", want.py,
                         rsp_tdata[2*CB-1:CB]);
                  fail_count++;
               end
               if (rsp_tdata[2*CB+LPG_COLOR_BITS-1:2*CB] !== want.color) begin
                  $error("pixel_colour: expected %h, actual %h", want.color,
                         rsp_tdata[2*CB+LPG_COLOR_BITS-1:2*CB]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_point: expected %0d, actual %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
            recv_stall = draw_wait(recv_calm);
         end else if (recv_stall != 0) begin
            recv_stall--;
         end
         rsp_tready <= (recv_stall == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      // next with no line pending
      add_next();
      // equal endpoints, then a next after the last point
      add_cmd(ACT_START, 5, 7, 5, 7, 16'h0000);
      add_next();
      add_next();
      // diagonal tie, endpoints swapped, falling minor
      add_cmd(ACT_START, COORD_MAX, 0, 0, COORD_MAX, 16'hFFFF, 1'b1);
      repeat (3) add_next();
      // steep line with negative minor delta
      add_cmd(ACT_START, 10, 20, 3, 30, 16'hA5A5);
      repeat (3) add_next();
      // flat at the top edge, replaced while pending
      add_cmd(ACT_START, 0, COORD_MAX, COORD_MAX, COORD_MAX, 16'h5A5A);
      add_next();
      // steep, swapped, runs to its last point
      add_cmd(ACT_START, COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MAX - 2, 16'h8001);
      repeat (4) add_next();
      // vertical full height
      add_cmd(ACT_START, 0, 0, 0, COORD_MAX, 16'h7FFE);
      repeat (2) add_next(1'b1);
      counted = 22;
      while (counted < ITEM_GOAL) add_random_line();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (cmds_due.size() != 0 || loaded) @(posedge clock);
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== line_point_generator.f =====
+incdir+rtl
rtl/lpg_pkg.sv
rtl/lpg_divider.sv
rtl/line_point_generator.sv
rtl/lpg_checker.sv
sim/line_point_generator_test.sv
